// ===== hw/rtl/ciu_pkg.sv =====
// Shared types, constants and the cosine remap table of the curve interpolation unit.
package ciu_pkg;

  // Field widths
  localparam int COORD_WIDTH     = 32;
  localparam int BLEND_FRAC_BITS = 16;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int MU_W            = BLEND_FRAC_BITS + 1;
  localparam int MODE_W          = 3;
  localparam int TENSION_W       = 18;
  localparam int TENSION_FRAC    = 16;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = TENSION_W;

  // Datapath widths
  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int COEF_W     = COORD_WIDTH + 4;
  localparam int WEIGHT_W   = BLEND_FRAC_BITS + 4;
  localparam int PRODUCT_W  = COEF_W + WEIGHT_W;
  localparam int TERM_W     = PRODUCT_W - BLEND_FRAC_BITS;
  localparam int SUM_W      = TERM_W + 3;
  localparam int TAN_PROD_W = DIFF_W + TENSION_W + 1;
  localparam int TAN_W      = TAN_PROD_W - TENSION_FRAC;
  localparam int COS_AW     = $clog2(COS_TABLE_DEPTH + 1);
  localparam int COS_PROD_W = MU_W + COS_AW;
  localparam int COS_STEP_W = MU_W + BLEND_FRAC_BITS + 2;

  localparam logic [MU_W-1:0] BLEND_ONE = {1'b1, {BLEND_FRAC_BITS{1'b0}}};

  // Interpolation methods; codes without a member act as linear
  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR   = 3'd0,
    MODE_COSINE   = 3'd1,
    MODE_CUBIC    = 3'd2,
    MODE_HERMITE  = 3'd3,
    MODE_CARDINAL = 3'd4
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_TENSION = 2'd1
  } reg_index_t;

  localparam logic [TENSION_W-1:0] TENSION_RESET = 18'd32768;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [TENSION_W-1:0] tension;
  } cfg_t;

  // Front half result handed to the weighting and summing half
  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic signed [COORD_WIDTH-1:0] v0;
    logic signed [COORD_WIDTH-1:0] v1;
    logic signed [COORD_WIDTH-1:0] v2;
    logic signed [COORD_WIDTH-1:0] v3;
    logic [MU_W-1:0]               mu;
    logic [MU_W-1:0]               mu2;
    logic [MU_W-1:0]               mu3;
    logic [MU_W-1:0]               cm;
    logic signed [COEF_W-1:0]      d21;
    logic signed [COEF_W-1:0]      p;
    logic signed [COEF_W-1:0]      q;
    logic signed [COEF_W-1:0]      r;
    logic signed [COEF_W-1:0]      t1;
    logic signed [COEF_W-1:0]      t2;
  } front_t;

  // Sign extensions
  function automatic logic signed [COEF_W-1:0] coef_of(input logic signed [COORD_WIDTH-1:0] v);
    return {{(COEF_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff_of(input logic signed [COORD_WIDTH-1:0] v);
    return {{(DIFF_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] weight_of(input logic [MU_W-1:0] m);
    return {{(WEIGHT_W-MU_W){1'b0}}, m};
  endfunction

  // Cosine table, built at elaboration: each entry holds {rom[k], rom[k+1]}
  typedef logic [2*MU_W-1:0] cos_pair_t;
  typedef cos_pair_t cos_rom_t [COS_TABLE_DEPTH+1];

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182, 64'd240};

  // cos(pi*k/D) in Q2.30 for an angle up to pi/2, Taylor series to x^16
  function automatic logic [63:0] cos_q30(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x    = (PI_Q30 * k) / COS_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    pos  = ONE_Q30;
    neg  = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // (1 - cos(pi*k/D)) / 2 in Q0.F, rounded half up, clamped to one
  function automatic logic [MU_W-1:0] cos_entry(input logic [63:0] k);
    logic [63:0] c;
    logic [63:0] r;
    if (2 * k <= COS_TABLE_DEPTH) begin
      c = cos_q30(k);
      if (c > ONE_Q30) c = ONE_Q30;
      r = (ONE_Q30 - c) >> 1;
    end else begin
      r = (ONE_Q30 + cos_q30(COS_TABLE_DEPTH - k)) >> 1;
    end
    r = (r + (64'd1 << (29 - BLEND_FRAC_BITS))) >> (30 - BLEND_FRAC_BITS);
    if (r > 64'(BLEND_ONE)) r = 64'(BLEND_ONE);
    return r[MU_W-1:0];
  endfunction

  function automatic cos_rom_t cos_rom_build();
    cos_rom_t        rom;
    logic [MU_W-1:0] cur;
    logic [MU_W-1:0] nxt;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      cur = cos_entry(64'(k));
      nxt = (k < COS_TABLE_DEPTH) ? cos_entry(64'(k + 1)) : cur;
      rom[k] = {cur, nxt};
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = cos_rom_build();

endpackage

// ===== hw/rtl/ciu_if.sv =====
// Request, result and configuration channels of the curve interpolation unit.
interface ciu_req_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  pt0;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  pt1;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  pt2;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  pt3;
  logic [ciu_pkg::MU_W-1:0]                blend;

  modport source (output valid, pt0, pt1, pt2, pt3, blend, input ready);
  modport sink   (input valid, pt0, pt1, pt2, pt3, blend, output ready);
endinterface

interface ciu_res_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  result_coord;
  logic                                    saturated;

  modport source (output valid, result_coord, saturated, input ready);
  modport sink   (input valid, result_coord, saturated, output ready);
endinterface

interface ciu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ciu_pkg::CFG_INDEX_W-1:0]  index;
  logic [ciu_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ciu_cfg_regs.sv =====
// Mode and tension configuration registers.
module ciu_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ciu_cfg_if.sink       cfg,
  output ciu_pkg::cfg_t regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode    <= ciu_pkg::MODE_LINEAR;
      regs.tension <= ciu_pkg::TENSION_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ciu_pkg::REG_MODE:    regs.mode    <= cfg.data[ciu_pkg::MODE_W-1:0];
        ciu_pkg::REG_TENSION: regs.tension <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ciu_cos_rom.sv =====
// Cosine remap table with a registered read of an entry pair.
module ciu_cos_rom (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ciu_pkg::COS_AW-1:0]   addr,
  output ciu_pkg::cos_pair_t           data
);

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ciu_pkg::COS_ROM[addr];
    end
  end

endmodule

// ===== hw/rtl/ciu_front.sv =====
// Front half: blend clamp, table read, blend powers, differences and tangents.
module ciu_front (
  input  logic            clk,
  input  logic            rst,
  ciu_req_if.sink         request,
  input  ciu_pkg::cfg_t   cfg,
  output ciu_pkg::front_t fwd,
  output logic            fwd_valid,
  input  logic            fwd_ready
);

  // Stage advance chain
  logic a_valid, b_valid, c_valid;
  logic adv_a, adv_b, adv_c;

  assign adv_c         = !c_valid || fwd_ready;
  assign adv_b         = !b_valid || adv_c;
  assign adv_a         = !a_valid || adv_b;
  assign request.ready = adv_a;
  assign fwd_valid     = c_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= request.valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) c_valid <= b_valid;
    end
  end

  // Stage A: clamp blend, form table address and fraction
  logic [ciu_pkg::MU_W-1:0]                mu_sat;
  logic [ciu_pkg::COS_PROD_W-1:0]          cos_prod;
  logic [ciu_pkg::MODE_W-1:0]              a_mode;
  logic [ciu_pkg::TENSION_W-1:0]           a_tension;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  a_v0, a_v1, a_v2, a_v3;
  logic [ciu_pkg::MU_W-1:0]                a_mu;
  logic [ciu_pkg::BLEND_FRAC_BITS-1:0]     a_frac;
  ciu_pkg::cos_pair_t                      a_pair;

  assign mu_sat   = (request.blend > ciu_pkg::BLEND_ONE) ? ciu_pkg::BLEND_ONE : request.blend;
  assign cos_prod = ciu_pkg::COS_PROD_W'(mu_sat) *
                    ciu_pkg::COS_PROD_W'(ciu_pkg::COS_TABLE_DEPTH);

  ciu_cos_rom u_cos_rom (
    .clk  (clk),
    .en   (adv_a),
    .addr (cos_prod[ciu_pkg::BLEND_FRAC_BITS +: ciu_pkg::COS_AW]),
    .data (a_pair)
  );

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_mode    <= cfg.mode;
      a_tension <= cfg.tension;
      a_v0      <= request.pt0;
      a_v1      <= request.pt1;
      a_v2      <= request.pt2;
      a_v3      <= request.pt3;
      a_mu      <= mu_sat;
      a_frac    <= cos_prod[ciu_pkg::BLEND_FRAC_BITS-1:0];
    end
  end

  // Stage B: mu squared, cosine interpolation, point differences
  logic [2*ciu_pkg::MU_W-1:0]              sq;
  logic [ciu_pkg::MU_W-1:0]                cbase, cnext;
  logic signed [ciu_pkg::MU_W:0]           cdiff;
  logic signed [ciu_pkg::COS_STEP_W-1:0]   cprod;
  logic signed [ciu_pkg::MU_W+1:0]         cm_full;
  logic signed [ciu_pkg::COEF_W-1:0]       e0, e1, e2, e3, d32, d01, p_val;

  logic [ciu_pkg::MODE_W-1:0]              b_mode;
  logic [ciu_pkg::TENSION_W-1:0]           b_tension;
  logic signed [ciu_pkg::COORD_WIDTH-1:0]  b_v0, b_v1, b_v2, b_v3;
  logic [ciu_pkg::MU_W-1:0]                b_mu, b_mu2, b_cm;
  logic signed [ciu_pkg::COEF_W-1:0]       b_d21, b_p, b_q, b_r;
  logic signed [ciu_pkg::DIFF_W-1:0]       b_ta, b_tb;

  always_comb begin
    sq      = a_mu * a_mu;
    cbase   = a_pair[2*ciu_pkg::MU_W-1:ciu_pkg::MU_W];
    cnext   = a_pair[ciu_pkg::MU_W-1:0];
    cdiff   = $signed({1'b0, cnext}) - $signed({1'b0, cbase});
    cprod   = cdiff * $signed({1'b0, a_frac});
    // floor of the step toward the next entry
    cm_full = $signed({2'b00, cbase}) +
              $signed(cprod[ciu_pkg::COS_STEP_W-1:ciu_pkg::BLEND_FRAC_BITS]);
    e0      = ciu_pkg::coef_of(a_v0);
    e1      = ciu_pkg::coef_of(a_v1);
    e2      = ciu_pkg::coef_of(a_v2);
    e3      = ciu_pkg::coef_of(a_v3);
    d32     = e3 - e2;
    d01     = e0 - e1;
    p_val   = d32 - d01;
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_mode    <= a_mode;
      b_tension <= a_tension;
      b_v0      <= a_v0;
      b_v1      <= a_v1;
      b_v2      <= a_v2;
      b_v3      <= a_v3;
      b_mu      <= a_mu;
      b_mu2     <= sq[ciu_pkg::BLEND_FRAC_BITS +: ciu_pkg::MU_W];
      b_cm      <= cm_full[ciu_pkg::MU_W-1:0];
      b_d21     <= e2 - e1;
      b_p       <= p_val;
      b_q       <= d01 - p_val;
      b_r       <= e2 - e0;
      b_ta      <= ciu_pkg::diff_of(a_v2) - ciu_pkg::diff_of(a_v0);
      b_tb      <= ciu_pkg::diff_of(a_v3) - ciu_pkg::diff_of(a_v1);
    end
  end

  // Stage C: mu cubed and cardinal tangents
  logic [2*ciu_pkg::MU_W-1:0]              cube;
  logic signed [ciu_pkg::TAN_PROD_W-1:0]   tp1, tp2, tscale;

  always_comb begin
    cube   = b_mu2 * b_mu;
    tscale = ciu_pkg::TAN_PROD_W'($signed({1'b0, b_tension}));
    tp1    = ciu_pkg::TAN_PROD_W'(b_ta) * tscale;
    tp2    = ciu_pkg::TAN_PROD_W'(b_tb) * tscale;
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      fwd.mode <= b_mode;
      fwd.v0   <= b_v0;
      fwd.v1   <= b_v1;
      fwd.v2   <= b_v2;
      fwd.v3   <= b_v3;
      fwd.mu   <= b_mu;
      fwd.mu2  <= b_mu2;
      fwd.mu3  <= cube[ciu_pkg::BLEND_FRAC_BITS +: ciu_pkg::MU_W];
      fwd.cm   <= b_cm;
      fwd.d21  <= b_d21;
      fwd.p    <= b_p;
      fwd.q    <= b_q;
      fwd.r    <= b_r;
      fwd.t1   <= ciu_pkg::COEF_W'($signed(tp1[ciu_pkg::TAN_PROD_W-1:ciu_pkg::TENSION_FRAC]));
      fwd.t2   <= ciu_pkg::COEF_W'($signed(tp2[ciu_pkg::TAN_PROD_W-1:ciu_pkg::TENSION_FRAC]));
    end
  end

endmodule

// ===== hw/rtl/ciu_back.sv =====
// Back half: method select, four weighted products, sum and saturation.
module ciu_back (
  input  logic            clk,
  input  logic            rst,
  input  ciu_pkg::front_t fwd,
  input  logic            fwd_valid,
  output logic            fwd_ready,
  ciu_res_if.source       result
);

  // Stage advance chain
  logic d_valid, e_valid, f_valid, g_valid;
  logic adv_d, adv_e, adv_f, adv_g;

  assign adv_g        = !g_valid || result.ready;
  assign adv_f        = !f_valid || adv_g;
  assign adv_e        = !e_valid || adv_f;
  assign adv_d        = !d_valid || adv_e;
  assign fwd_ready    = adv_d;
  assign result.valid = g_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else begin
      if (adv_d) d_valid <= fwd_valid;
      if (adv_e) e_valid <= d_valid;
      if (adv_f) f_valid <= e_valid;
      if (adv_g) g_valid <= f_valid;
    end
  end

  // Stage D: basis weights and operand select per method
  logic signed [ciu_pkg::WEIGHT_W-1:0] wm, wm2, wm3, wcm, wone;
  logic signed [ciu_pkg::WEIGHT_W-1:0] h1, h2, h3, h4;
  logic signed [ciu_pkg::COEF_W-1:0]   c_sel [4];
  logic signed [ciu_pkg::WEIGHT_W-1:0] w_sel [4];
  logic signed [ciu_pkg::COEF_W-1:0]   base_sel;
  logic signed [ciu_pkg::COEF_W-1:0]   zero_c;
  logic signed [ciu_pkg::WEIGHT_W-1:0] zero_w;

  logic signed [ciu_pkg::COEF_W-1:0]   d_c [4];
  logic signed [ciu_pkg::WEIGHT_W-1:0] d_w [4];
  logic signed [ciu_pkg::COEF_W-1:0]   d_base;

  always_comb begin
    zero_c = '0;
    zero_w = '0;
    wm     = ciu_pkg::weight_of(fwd.mu);
    wm2    = ciu_pkg::weight_of(fwd.mu2);
    wm3    = ciu_pkg::weight_of(fwd.mu3);
    wcm    = ciu_pkg::weight_of(fwd.cm);
    wone   = ciu_pkg::weight_of(ciu_pkg::BLEND_ONE);
    h1     = wm3 + wm3 - wm2 - wm2 - wm2 + wone;
    h2     = wm2 + wm2 + wm2 - wm3 - wm3;
    h3     = wm3 - wm2 - wm2 + wm;
    h4     = wm3 - wm2;
    case (fwd.mode)
      ciu_pkg::MODE_COSINE: begin
        c_sel    = '{fwd.d21, zero_c, zero_c, zero_c};
        w_sel    = '{wcm, zero_w, zero_w, zero_w};
        base_sel = ciu_pkg::coef_of(fwd.v1);
      end
      ciu_pkg::MODE_CUBIC: begin
        c_sel    = '{fwd.p, fwd.q, fwd.r, zero_c};
        w_sel    = '{wm3, wm2, wm, zero_w};
        base_sel = ciu_pkg::coef_of(fwd.v1);
      end
      ciu_pkg::MODE_HERMITE: begin
        c_sel    = '{ciu_pkg::coef_of(fwd.v1), ciu_pkg::coef_of(fwd.v2),
                     ciu_pkg::coef_of(fwd.v0), ciu_pkg::coef_of(fwd.v3)};
        w_sel    = '{h1, h2, h3, h4};
        base_sel = zero_c;
      end
      ciu_pkg::MODE_CARDINAL: begin
        c_sel    = '{ciu_pkg::coef_of(fwd.v1), ciu_pkg::coef_of(fwd.v2), fwd.t1, fwd.t2};
        w_sel    = '{h1, h2, h3, h4};
        base_sel = zero_c;
      end
      default: begin
        // linear, and the unused codes
        c_sel    = '{fwd.d21, zero_c, zero_c, zero_c};
        w_sel    = '{wm, zero_w, zero_w, zero_w};
        base_sel = ciu_pkg::coef_of(fwd.v1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      d_c    <= c_sel;
      d_w    <= w_sel;
      d_base <= base_sel;
    end
  end

  // Stage E: four products, each floored to Q16.16
  logic signed [ciu_pkg::PRODUCT_W-1:0] prod [4];
  logic signed [ciu_pkg::TERM_W-1:0]    e_term [4];
  logic signed [ciu_pkg::COEF_W-1:0]    e_base;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = d_c[i] * d_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e) begin
      for (int i = 0; i < 4; i++) begin
        e_term[i] <= $signed(prod[i][ciu_pkg::PRODUCT_W-1:ciu_pkg::BLEND_FRAC_BITS]);
      end
      e_base <= d_base;
    end
  end

  // Stage F: two partial sums
  logic signed [ciu_pkg::SUM_W-1:0] f_sum_a, f_sum_b;

  always_ff @(posedge clk) begin
    if (adv_f) begin
      f_sum_a <= ciu_pkg::SUM_W'(e_term[0]) + ciu_pkg::SUM_W'(e_term[1]);
      f_sum_b <= ciu_pkg::SUM_W'(e_term[2]) + ciu_pkg::SUM_W'(e_term[3]) +
                 ciu_pkg::SUM_W'(e_base);
    end
  end

  // Stage G: final sum and clip to the coordinate range
  logic signed [ciu_pkg::SUM_W-1:0]                 total;
  logic [ciu_pkg::SUM_W-ciu_pkg::COORD_WIDTH:0]      upper;
  logic                                             ovf;

  always_comb begin
    total = f_sum_a + f_sum_b;
    upper = total[ciu_pkg::SUM_W-1:ciu_pkg::COORD_WIDTH-1];
    ovf   = !((&upper) || !(|upper));
  end

  always_ff @(posedge clk) begin
    if (adv_g) begin
      result.saturated <= ovf;
      if (ovf) begin
        result.result_coord <= {total[ciu_pkg::SUM_W-1],
                                {(ciu_pkg::COORD_WIDTH-1){~total[ciu_pkg::SUM_W-1]}}};
      end else begin
        result.result_coord <= total[ciu_pkg::COORD_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/curve_interpolation_unit.sv =====
// Curve interpolation unit top level.
// One axis per request: four control values and a blend position give one
// Q16.16 coordinate by linear, cosine, cubic, hermite or cardinal blending, chosen
// by the mode register. The unit takes a request every cycle unless stalled from the
// result side; each request runs through seven register stages (clamp and table read,
// blend square and cosine step, blend cube and tangents, method select, four 36x20
// products, two partial sums, final sum with clipping) before its result is offered.
// A stall at the result side holds each stage only where the next is full, so
// requests keep entering while bubbles remain. The pace is one request per cycle
// while the result side takes results: every stage does its share, at most one
// multiply per operand pair, and the 1025-entry cosine table is read once per request
// through its one port. Configuration writes complete in the cycle they are offered
// and must be made while no request is in flight.
module curve_interpolation_unit (
  input  logic       clk,
  input  logic       rst,
  ciu_req_if.sink    request,
  ciu_res_if.source  result,
  ciu_cfg_if.sink    cfg
);

  ciu_pkg::cfg_t   regs;
  ciu_pkg::front_t fwd;
  logic            fwd_valid;
  logic            fwd_ready;

  // Configuration registers
  ciu_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Blend powers, table remap, differences, tangents
  ciu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg       (regs),
    .fwd       (fwd),
    .fwd_valid (fwd_valid),
    .fwd_ready (fwd_ready)
  );

  // Weighted sum and output register
  ciu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fwd       (fwd),
    .fwd_valid (fwd_valid),
    .fwd_ready (fwd_ready),
    .result    (result)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the curve interpolation unit: all methods, tension range, saturation.
module tb;
  import ciu_pkg::*;

  localparam int     PIPE_LATENCY = 7;
  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     DRAIN_LIMIT  = 5000;
  localparam longint COORD_MAX    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN    = -COORD_MAX - 1;
  localparam longint BLEND_UNIT   = longint'(1) <<< BLEND_FRAC_BITS;

  // Q2.30 constants of the cosine table build
  localparam bit [63:0] PI_FIX30   = 64'd3373259426;
  localparam bit [63:0] UNIT_FIX30 = 64'd1073741824;

  localparam logic signed [COORD_WIDTH-1:0] COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Codes with no meaning in the block
  localparam logic [MODE_W-1:0]      MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0]      MODE_SPARE_LAST  = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B      = 2'd3;

  localparam logic [TENSION_W-1:0] TENSION_ZERO = '0;
  localparam logic [TENSION_W-1:0] TENSION_TWO  = 18'd131072;
  localparam logic [TENSION_W-1:0] TENSION_FULL = '1;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] coord;
    logic                          sat;
  } coord_result_t;

  logic clk;
  logic rst;

  ciu_req_if req_ch ();
  ciu_res_if res_ch ();
  ciu_cfg_if cfg_ch ();

  curve_interpolation_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  // Shadow registers and bookkeeping
  logic [MODE_W-1:0]    active_mode;
  logic [TENSION_W-1:0] active_tension;
  logic [MU_W-1:0]      remap_table [0:COS_TABLE_DEPTH];
  coord_result_t        expected_coords [$];
  coord_result_t        head_coord;
  int                   mismatch_count;
  int                   requests_sent;
  int                   results_checked;
  int                   clipped_count;
  int                   settings_count;
  int                   cycle_count = 0;
  int                   stall_left = 0;
  bit                   quiet_mode;
  bit                   sender_calm;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("curve_interpolation_unit verification failed");
      $finish;
    end
  end

  // cos(pi*k/D) magnitude in Q2.30, angle up to pi/2, Taylor terms to x^16
  function automatic bit [63:0] cos_fix30(input bit [63:0] k);
    bit [63:0] x;
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] pos;
    bit [63:0] neg;
    bit [63:0] div;
    x    = (PI_FIX30 * k) / COS_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = UNIT_FIX30;
    pos  = UNIT_FIX30;
    neg  = '0;
    for (int n = 1; n <= 8; n++) begin
      div  = 64'((2 * n - 1) * (2 * n));
      term = ((term * x2) >> 30) / div;
      if (n % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return (pos > neg) ? pos - neg : '0;
  endfunction

  // Remap table: (1 - cos(pi*k/D)) / 2 in Q0.F, upper half by symmetry
  initial begin : build_remap
    bit [63:0] c;
    bit [63:0] r;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      if (2 * k <= COS_TABLE_DEPTH) begin
        c = cos_fix30(64'(k));
        if (c > UNIT_FIX30) c = UNIT_FIX30;
        r = (UNIT_FIX30 - c) >> 1;
      end else begin
        r = (UNIT_FIX30 + cos_fix30(64'(COS_TABLE_DEPTH - k))) >> 1;
      end
      r = (r + (64'd1 << (29 - BLEND_FRAC_BITS))) >> (30 - BLEND_FRAC_BITS);
      if (r > 64'(BLEND_ONE)) r = 64'(BLEND_ONE);
      remap_table[k] = r[MU_W-1:0];
    end
  end

  // floor(a*m / 2^f)
  function automatic longint scale_floor(input longint a, input longint m, input int f);
    return (a * m) >>> f;
  endfunction

  // Table lookup plus floored step toward the next entry
  function automatic longint cosine_blend(input longint mu);
    longint prod;
    longint idx;
    longint fr;
    longint base;
    longint diff;
    prod = mu * COS_TABLE_DEPTH;
    idx  = prod >>> BLEND_FRAC_BITS;
    fr   = prod & (BLEND_UNIT - 1);
    if (idx >= COS_TABLE_DEPTH) return longint'(remap_table[COS_TABLE_DEPTH]);
    base = longint'(remap_table[idx]);
    diff = longint'(remap_table[idx + 1]) - base;
    return base + scale_floor(diff, fr, BLEND_FRAC_BITS);
  endfunction

  function automatic longint hermite_sum(input longint v1, input longint v2,
                                         input longint t1, input longint t2,
                                         input longint mu, input longint mu2,
                                         input longint mu3);
    longint h1;
    longint h2;
    longint h3;
    longint h4;
    h1 = 2 * mu3 - 3 * mu2 + BLEND_UNIT;
    h2 = 3 * mu2 - 2 * mu3;
    h3 = mu3 - 2 * mu2 + mu;
    h4 = mu3 - mu2;
    return scale_floor(v1, h1, BLEND_FRAC_BITS) + scale_floor(v2, h2, BLEND_FRAC_BITS)
         + scale_floor(t1, h3, BLEND_FRAC_BITS) + scale_floor(t2, h4, BLEND_FRAC_BITS);
  endfunction

  // Expected coordinate of one request under the current registers
  function automatic coord_result_t predict_coord(input logic signed [COORD_WIDTH-1:0] a0,
                                                  input logic signed [COORD_WIDTH-1:0] a1,
                                                  input logic signed [COORD_WIDTH-1:0] a2,
                                                  input logic signed [COORD_WIDTH-1:0] a3,
                                                  input logic [MU_W-1:0] blend_raw);
    longint        v0;
    longint        v1;
    longint        v2;
    longint        v3;
    longint        mu;
    longint        mu2;
    longint        mu3;
    longint        p;
    longint        q;
    longint        r;
    longint        res;
    coord_result_t outc;
    v0  = a0;
    v1  = a1;
    v2  = a2;
    v3  = a3;
    mu  = (blend_raw > BLEND_ONE) ? BLEND_UNIT : longint'(blend_raw);
    mu2 = scale_floor(mu, mu, BLEND_FRAC_BITS);
    mu3 = scale_floor(mu2, mu, BLEND_FRAC_BITS);
    case (active_mode)
      MODE_COSINE: res = v1 + scale_floor(v2 - v1, cosine_blend(mu), BLEND_FRAC_BITS);
      MODE_CUBIC: begin
        p   = (v3 - v2) - (v0 - v1);
        q   = (v0 - v1) - p;
        r   = v2 - v0;
        res = scale_floor(p, mu3, BLEND_FRAC_BITS) + scale_floor(q, mu2, BLEND_FRAC_BITS)
            + scale_floor(r, mu, BLEND_FRAC_BITS) + v1;
      end
      MODE_HERMITE: res = hermite_sum(v1, v2, v0, v3, mu, mu2, mu3);
      MODE_CARDINAL: begin
        res = hermite_sum(v1, v2,
                          scale_floor(v2 - v0, longint'(active_tension), TENSION_FRAC),
                          scale_floor(v3 - v1, longint'(active_tension), TENSION_FRAC),
                          mu, mu2, mu3);
      end
      default: res = v1 + scale_floor(v2 - v1, mu, BLEND_FRAC_BITS);
    endcase
    outc.sat = 1'b0;
    if (res > COORD_MAX) begin
      res      = COORD_MAX;
      outc.sat = 1'b1;
    end else if (res < COORD_MIN) begin
      res      = COORD_MIN;
      outc.sat = 1'b1;
    end
    outc.coord = res[COORD_WIDTH-1:0];
    return outc;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Result side: random stall bursts, none in quiet mode
  always @(posedge clk) begin
    if (quiet_mode) begin
      stall_left   <= 0;
      res_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left   <= $urandom_range(0, 15);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_coords.size() == 0) begin
        report_mismatch($sformatf("result %h sat %b with nothing pending",
                                  res_ch.result_coord, res_ch.saturated));
      end else begin
        head_coord = expected_coords.pop_front();
        if (res_ch.result_coord !== head_coord.coord)
          report_mismatch($sformatf("result_coord %h, predicted %h",
                                    res_ch.result_coord, head_coord.coord));
        if (res_ch.saturated !== head_coord.sat)
          report_mismatch($sformatf("saturated %b, predicted %b (coord %h)",
                                    res_ch.saturated, head_coord.sat, head_coord.coord));
        results_checked++;
      end
    end
  end

  // Send one request, optionally after an idle burst; predicts at acceptance
  task automatic send_coord_item(input logic signed [COORD_WIDTH-1:0] a0,
                                 input logic signed [COORD_WIDTH-1:0] a1,
                                 input logic signed [COORD_WIDTH-1:0] a2,
                                 input logic signed [COORD_WIDTH-1:0] a3,
                                 input logic [MU_W-1:0] bl);
    int            gap;
    coord_result_t want;
    gap = 0;
    if (!quiet_mode && !sender_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.pt0   <= a0;
    req_ch.pt1   <= a1;
    req_ch.pt2   <= a2;
    req_ch.pt3   <= a3;
    req_ch.blend <= bl;
    do @(posedge clk); while (!req_ch.ready);
    want = predict_coord(a0, a1, a2, a3, bl);
    expected_coords.push_back(want);
    requests_sent++;
    if (want.sat) clipped_count++;
  endtask

  // Wait for every pending result, then let the pipeline settle
  task automatic drain_results();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_coords.size() != 0 && waited < DRAIN_LIMIT);
    if (expected_coords.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_coords.size()));
      expected_coords.delete();
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Register write, only with the unit idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MODE:    active_mode = value[MODE_W-1:0];
      REG_TENSION: active_tension = value[TENSION_W-1:0];
      default:     ;
    endcase
    settings_count++;
  endtask

  // Random coordinate: extremes, near extremes, small values or anything
  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    logic signed [COORD_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = COORD_HI - $urandom_range(0, 255);
      1:       v = COORD_LO + $urandom_range(0, 255);
      2:       v = ($urandom_range(0, 1)) ? COORD_HI : COORD_LO;
      3, 4, 5: v = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [MU_W-1:0] rand_blend();
    logic [MU_W-1:0] b;
    case ($urandom_range(0, 9))
      0:       b = BLEND_ONE;
      1:       b = '0;
      2:       b = MU_W'($urandom);
      default: b = MU_W'($urandom_range(0, BLEND_ONE));
    endcase
    return b;
  endfunction

  // Reset values: linear mode, Catmull-Rom tension
  task automatic test_reset_state();
    send_coord_item('0, COORD_LO, COORD_HI, '0, '0);
    send_coord_item('0, COORD_LO, COORD_HI, '0, BLEND_ONE);
    write_reg(REG_MODE, MODE_CARDINAL);
    send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 17'd32768);
  endtask

  // Linear and cosine blends, blend at zero, half, just below one and above one
  task automatic test_linear_cosine();
    write_reg(REG_MODE, MODE_LINEAR);
    send_coord_item(rand_coord(), COORD_HI, COORD_LO, rand_coord(), '1);
    send_coord_item('0, 32'sh10000, -32'sh30000, '0, 17'd32768);
    write_reg(REG_MODE, MODE_COSINE);
    send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), '0);
    send_coord_item(rand_coord(), COORD_LO, COORD_HI, rand_coord(), BLEND_ONE - 1);
    send_coord_item(rand_coord(), COORD_LO, COORD_HI, rand_coord(), 17'd32768);
    send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), '1);
  endtask

  // Cubic and hermite, driven with extreme control values
  task automatic test_polynomials();
    write_reg(REG_MODE, MODE_CUBIC);
    send_coord_item(COORD_LO, COORD_HI, COORD_LO, COORD_HI, 17'd32768);
    send_coord_item(COORD_HI, COORD_LO, COORD_HI, COORD_LO, 17'd21845);
    send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), BLEND_ONE);
    write_reg(REG_MODE, MODE_HERMITE);
    send_coord_item(COORD_HI, COORD_HI, COORD_HI, COORD_HI, 17'd32768);
    send_coord_item(COORD_LO, COORD_LO, COORD_LO, COORD_LO, 17'd49152);
    send_coord_item(COORD_HI, '0, '0, COORD_LO, 17'd16384);
  endtask

  // Cardinal at tension zero, two and the full 18-bit value
  task automatic test_cardinal_tension();
    write_reg(REG_MODE, MODE_CARDINAL);
    write_reg(REG_TENSION, TENSION_ZERO);
    send_coord_item(COORD_LO, COORD_HI, COORD_LO, COORD_HI, 17'd32768);
    write_reg(REG_TENSION, TENSION_TWO);
    send_coord_item(COORD_LO, COORD_HI, COORD_LO, COORD_HI, 17'd32768);
    write_reg(REG_TENSION, TENSION_FULL);
    send_coord_item(COORD_HI, COORD_LO, COORD_HI, COORD_LO, 17'd40000);
  endtask

  // Spare mode codes act as linear; spare register indexes change nothing
  task automatic test_spare_codes();
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
      write_reg(REG_MODE, CFG_DATA_W'(m));
      send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_blend());
    end
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_MODE, MODE_CARDINAL);
    send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_blend());
  endtask

  // Random phases, each with its own method and tension
  task automatic test_random_phases();
    logic [MODE_W-1:0]     code;
    logic [TENSION_W-1:0]  tens;
    logic [CFG_DATA_W-1:0] rnd;
    for (int ph = 0; ph < 11; ph++) begin
      if (ph <= MODE_SPARE_LAST) code = MODE_W'(ph);
      else                       code = MODE_W'($urandom_range(MODE_LINEAR, MODE_CARDINAL));
      case (ph % 5)
        0:       tens = TENSION_ZERO;
        1:       tens = TENSION_TWO;
        2:       tens = TENSION_FULL;
        3:       tens = TENSION_RESET;
        default: tens = TENSION_W'($urandom);
      endcase
      rnd = CFG_DATA_W'($urandom);
      write_reg(REG_TENSION, tens);
      write_reg(REG_MODE, {rnd[CFG_DATA_W-1:MODE_W], code});
      sender_calm = ($urandom_range(0, 3) == 0);
      repeat (160)
        send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_blend());
    end
    sender_calm = 1'b0;
  endtask

  // Last stretch at full rate on both sides
  task automatic test_quiet_tail();
    write_reg(REG_TENSION, TENSION_W'($urandom));
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(MODE_LINEAR, MODE_CARDINAL)));
    quiet_mode = 1'b1;
    repeat (140)
      send_coord_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_blend());
  endtask

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.pt0      <= '0;
    req_ch.pt1      <= '0;
    req_ch.pt2      <= '0;
    req_ch.pt3      <= '0;
    req_ch.blend    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    mismatch_count  = 0;
    requests_sent   = 0;
    results_checked = 0;
    clipped_count   = 0;
    settings_count  = 0;
    quiet_mode      = 1'b0;
    sender_calm     = 1'b0;
    active_mode     = MODE_LINEAR;
    active_tension  = TENSION_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_linear_cosine();
    test_polynomials();
    test_cardinal_tension();
    test_spare_codes();
    test_random_phases();
    test_quiet_tail();
    drain_results();

    $display("%0d requests, %0d results checked, %0d of them clipped", requests_sent,
             results_checked, clipped_count);
    $display("%0d register writes over all five methods, spare codes and tension extremes",
             settings_count);
    if (mismatch_count == 0) begin
      $display("curve_interpolation_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("curve_interpolation_unit verification failed");
    end
    $finish;
  end

endmodule
